// ===== design/coap_mp_pkg.sv =====
package coap_mp_pkg;

    localparam int unsigned MAX_OPTIONS = 16;
    localparam int unsigned MAX_TOKEN   = 8;

    // option counter must reach MAX_OPTIONS itself
    localparam int unsigned OPT_CNT_W = $clog2(MAX_OPTIONS + 1);

    // event kinds
    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_HEADER  = 3'd1;
    localparam logic [2:0] KIND_TOKEN   = 3'd2;
    localparam logic [2:0] KIND_OPTION  = 3'd3;
    localparam logic [2:0] KIND_VALUE   = 3'd4;
    localparam logic [2:0] KIND_PAYLOAD = 3'd5;

    // datagram status
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT   = 3'd1;
    localparam logic [2:0] ST_BAD_VERSION = 3'd2;
    localparam logic [2:0] ST_BAD_TOKEN   = 3'd3;
    localparam logic [2:0] ST_TOO_MANY    = 3'd4;
    localparam logic [2:0] ST_OVERRUN     = 3'd5;

    localparam logic [7:0] PAYLOAD_MARKER = 8'hFF;
    localparam logic [3:0] NIB_EXT1       = 4'd13;
    localparam logic [3:0] NIB_EXT2       = 4'd14;
    localparam logic [15:0] EXT1_BIAS     = 16'd13;
    localparam logic [15:0] EXT2_BIAS     = 16'd269;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  msg_type;
        logic [3:0]  token_len;
        logic [7:0]  code;
        logic [15:0] msg_id;
        logic [15:0] option_number;
        logic [15:0] option_length;
        logic [7:0]  byte_out;
        logic        message_end;
        logic [2:0]  status;
    } t_result;

endpackage

// ===== design/coap_mp_in_if.sv =====
interface coap_mp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== design/coap_mp_out_if.sv =====
interface coap_mp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [1:0]  msg_type;
    logic [3:0]  token_len;
    logic [7:0]  code;
    logic [15:0] msg_id;
    logic [15:0] option_number;
    logic [15:0] option_length;
    logic [7:0]  byte_out;
    logic        message_end;
    logic [2:0]  status;

    modport source (
        output valid, output kind, output msg_type, output token_len, output code,
        output msg_id, output option_number, output option_length, output byte_out,
        output message_end, output status, input ready
    );
    modport sink (
        input valid, input kind, input msg_type, input token_len, input code,
        input msg_id, input option_number, input option_length, input byte_out,
        input message_end, input status, output ready
    );
endinterface

// ===== design/coap_mp_in_stage.sv =====
module coap_mp_in_stage (
    input  logic         i_clk,
    input  logic         i_rst_n,
    coap_mp_in_if.sink   i_in,
    input  logic         i_take,
    output logic         o_valid,
    output logic [7:0]   o_data_byte,
    output logic         o_last_byte
);

    logic       r_valid;
    logic [7:0] r_data_byte;
    logic       r_last_byte;

    // free when empty or when the held byte moves on this cycle
    assign i_in.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_data_byte <= i_in.data_byte;
            r_last_byte <= i_in.last_byte;
        end
    end

    assign o_valid     = r_valid;
    assign o_data_byte = r_data_byte;
    assign o_last_byte = r_last_byte;

endmodule

// ===== design/coap_mp_decode.sv =====
module coap_mp_decode
    import coap_mp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic [1:0]  i_expected_version,
    output logic        o_has_result,
    output t_result     o_result
);

    typedef enum logic [3:0] {
        PH_HEADER, PH_TOKEN, PH_OPT, PH_DEXT1, PH_DEXT2,
        PH_LEXT1, PH_LEXT2, PH_VALUE, PH_PAYLOAD, PH_DISCARD
    } t_phase;

    localparam logic [OPT_CNT_W-1:0] MAX_OPT_CNT   = OPT_CNT_W'(MAX_OPTIONS);
    localparam logic [3:0]           MAX_TOKEN_LEN = 4'(MAX_TOKEN);

    t_phase                 r_phase, n_phase;
    logic [1:0]             r_header_index, n_header_index;
    logic [1:0]             r_held_type, n_held_type;
    logic [3:0]             r_held_token_length, n_held_token_length;
    logic [7:0]             r_held_code, n_held_code;
    logic [15:0]            r_held_message_id, n_held_message_id;
    logic [3:0]             r_token_left, n_token_left;
    logic [3:0]             r_delta_nibble, n_delta_nibble;
    logic [3:0]             r_length_nibble, n_length_nibble;
    logic [7:0]             r_ext_high, n_ext_high;
    logic [15:0]            r_pending_delta, n_pending_delta;
    logic [15:0]            r_current_number, n_current_number;
    logic [15:0]            r_value_left, n_value_left;
    logic [OPT_CNT_W-1:0]   r_option_count, n_option_count;
    logic [2:0]             r_error_code, n_error_code;

    logic [2:0]  kind;
    logic [2:0]  err;
    logic [7:0]  bout;
    logic [15:0] olen;
    logic        do_length;
    logic        do_finish;

    function automatic logic [15:0] short_nibble(input logic [3:0] n);
        return (n < NIB_EXT1) ? {12'd0, n} : 16'd0;
    endfunction

    always_comb begin
        n_phase             = r_phase;
        n_header_index      = r_header_index;
        n_held_type         = r_held_type;
        n_held_token_length = r_held_token_length;
        n_held_code         = r_held_code;
        n_held_message_id   = r_held_message_id;
        n_token_left        = r_token_left;
        n_delta_nibble      = r_delta_nibble;
        n_length_nibble     = r_length_nibble;
        n_ext_high          = r_ext_high;
        n_pending_delta     = r_pending_delta;
        n_current_number    = r_current_number;
        n_value_left        = r_value_left;
        n_option_count      = r_option_count;
        n_error_code        = r_error_code;
        kind                = KIND_NONE;
        err                 = ST_OK;
        bout                = 8'd0;
        olen                = 16'd0;
        do_length           = 1'b0;
        do_finish           = 1'b0;

        unique case (r_phase)
            PH_HEADER: begin
                unique case (r_header_index)
                    2'd0: begin
                        n_held_type         = i_data_byte[5:4];
                        n_held_token_length = i_data_byte[3:0];
                        if (i_data_byte[7:6] != i_expected_version) begin
                            n_error_code = ST_BAD_VERSION;
                        end
                    end
                    2'd1:    n_held_code = i_data_byte;
                    2'd2:    n_held_message_id = {i_data_byte, 8'd0};
                    default: n_held_message_id = {r_held_message_id[15:8], i_data_byte};
                endcase
                if (r_header_index != 2'd3) begin
                    n_header_index = r_header_index + 2'd1;
                    if (i_last_byte) err = ST_TOO_SHORT;
                end else begin
                    n_header_index = 2'd0;
                    priority if (r_error_code == ST_BAD_VERSION) begin
                        err = ST_BAD_VERSION;
                    end else if (n_held_token_length > MAX_TOKEN_LEN) begin
                        err = ST_BAD_TOKEN;
                    end else if (n_held_token_length != 4'd0 && i_last_byte) begin
                        err = ST_BAD_TOKEN;
                    end else begin
                        n_token_left = n_held_token_length;
                        n_phase      = (n_held_token_length != 4'd0) ? PH_TOKEN : PH_OPT;
                        kind         = KIND_HEADER;
                    end
                end
            end
            PH_TOKEN: begin
                n_token_left = r_token_left - 4'd1;
                if (n_token_left == 4'd0) begin
                    n_phase = PH_OPT;
                    kind    = KIND_TOKEN;
                    bout    = i_data_byte;
                end else if (i_last_byte) begin
                    err = ST_BAD_TOKEN;
                end else begin
                    kind = KIND_TOKEN;
                    bout = i_data_byte;
                end
            end
            PH_OPT: begin
                priority if (i_data_byte == PAYLOAD_MARKER) begin
                    n_phase = PH_PAYLOAD;
                end else if (r_option_count >= MAX_OPT_CNT) begin
                    err = ST_TOO_MANY;
                end else begin
                    n_delta_nibble  = i_data_byte[7:4];
                    n_length_nibble = i_data_byte[3:0];
                    if (n_delta_nibble == NIB_EXT1 || n_delta_nibble == NIB_EXT2) begin
                        if (i_last_byte) err = ST_OVERRUN;
                        else n_phase = PH_DEXT1;
                    end else begin
                        n_pending_delta = short_nibble(n_delta_nibble);
                        do_length       = 1'b1;
                    end
                end
            end
            PH_DEXT1: begin
                if (r_delta_nibble == NIB_EXT1) begin
                    n_pending_delta = {8'd0, i_data_byte} + EXT1_BIAS;
                    do_length       = 1'b1;
                end else begin
                    n_ext_high = i_data_byte;
                    if (i_last_byte) err = ST_OVERRUN;
                    else n_phase = PH_DEXT2;
                end
            end
            PH_DEXT2: begin
                n_pending_delta = {r_ext_high, i_data_byte} + EXT2_BIAS;
                do_length       = 1'b1;
            end
            PH_LEXT1: begin
                if (r_length_nibble == NIB_EXT1) begin
                    n_value_left = {8'd0, i_data_byte} + EXT1_BIAS;
                    do_finish    = 1'b1;
                end else begin
                    n_ext_high = i_data_byte;
                    if (i_last_byte) err = ST_OVERRUN;
                    else n_phase = PH_LEXT2;
                end
            end
            PH_LEXT2: begin
                n_value_left = {r_ext_high, i_data_byte} + EXT2_BIAS;
                do_finish    = 1'b1;
            end
            PH_VALUE: begin
                n_value_left = r_value_left - 16'd1;
                if (n_value_left == 16'd0) begin
                    n_phase = PH_OPT;
                    kind    = KIND_VALUE;
                    bout    = i_data_byte;
                end else if (i_last_byte) begin
                    err = ST_OVERRUN;
                end else begin
                    kind = KIND_VALUE;
                    bout = i_data_byte;
                end
            end
            PH_PAYLOAD: begin
                kind = KIND_PAYLOAD;
                bout = i_data_byte;
            end
            default: begin
                // discarding: the stored error comes out on the last byte
                if (i_last_byte) err = r_error_code;
            end
        endcase

        // delta resolved, now the length nibble
        if (do_length) begin
            if (n_length_nibble == NIB_EXT1 || n_length_nibble == NIB_EXT2) begin
                if (i_last_byte) err = ST_OVERRUN;
                else n_phase = PH_LEXT1;
            end else begin
                n_value_left = short_nibble(n_length_nibble);
                do_finish    = 1'b1;
            end
        end

        // option header complete
        if (do_finish) begin
            n_current_number = r_current_number + n_pending_delta;
            if (n_value_left != 16'd0 && i_last_byte) begin
                err = ST_OVERRUN;
            end else begin
                n_option_count = r_option_count + OPT_CNT_W'(1);
                kind           = KIND_OPTION;
                olen           = n_value_left;
                n_phase        = (n_value_left != 16'd0) ? PH_VALUE : PH_OPT;
            end
        end

        if (err != ST_OK) begin
            kind         = KIND_NONE;
            bout         = 8'd0;
            olen         = 16'd0;
            n_error_code = err;
            n_phase      = PH_DISCARD;
        end
    end

    assign o_has_result = (kind != KIND_NONE) || i_last_byte;

    always_comb begin
        o_result.kind          = kind;
        o_result.msg_type      = (kind != KIND_NONE) ? n_held_type : 2'd0;
        o_result.token_len     = (kind != KIND_NONE) ? n_held_token_length : 4'd0;
        o_result.code          = (kind != KIND_NONE) ? n_held_code : 8'd0;
        o_result.msg_id        = (kind != KIND_NONE) ? n_held_message_id : 16'd0;
        o_result.option_number = (kind == KIND_OPTION || kind == KIND_VALUE) ?
                                 n_current_number : 16'd0;
        o_result.option_length = olen;
        o_result.byte_out      = bout;
        o_result.message_end   = i_last_byte;
        o_result.status        = i_last_byte ? n_error_code : ST_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last_byte)) begin
            r_phase             <= PH_HEADER;
            r_header_index      <= 2'd0;
            r_held_type         <= 2'd0;
            r_held_token_length <= 4'd0;
            r_held_code         <= 8'd0;
            r_held_message_id   <= 16'd0;
            r_token_left        <= 4'd0;
            r_delta_nibble      <= 4'd0;
            r_length_nibble     <= 4'd0;
            r_ext_high          <= 8'd0;
            r_pending_delta     <= 16'd0;
            r_current_number    <= 16'd0;
            r_value_left        <= 16'd0;
            r_option_count      <= '0;
            r_error_code        <= ST_OK;
        end else if (i_step) begin
            r_phase             <= n_phase;
            r_header_index      <= n_header_index;
            r_held_type         <= n_held_type;
            r_held_token_length <= n_held_token_length;
            r_held_code         <= n_held_code;
            r_held_message_id   <= n_held_message_id;
            r_token_left        <= n_token_left;
            r_delta_nibble      <= n_delta_nibble;
            r_length_nibble     <= n_length_nibble;
            r_ext_high          <= n_ext_high;
            r_pending_delta     <= n_pending_delta;
            r_current_number    <= n_current_number;
            r_value_left        <= n_value_left;
            r_option_count      <= n_option_count;
            r_error_code        <= n_error_code;
        end
    end

endmodule

// ===== design/coap_message_parser.sv =====
// channel   dir   handshake       payload
// i_in      in    valid / ready   data_byte[7:0], last_byte
// o_out     out   valid / ready   kind, msg_type, token_len, code, msg_id,
//                                 option_number, option_length, byte_out,
//                                 message_end, status
// cfg       in    i_cfg_we        i_cfg_wdata[1:0] (expected version)
//
// one byte per cycle while the output is not stalled; a result reaches o_out after the input
// transfer of its byte through the input register, then decode into the result register
// the byte at the input register moves on only when the result register is free,
// so a stalled output holds at most two bytes inside before i_in.ready drops
// synchronous active-low reset clears the parse state, empties both registers
// and sets the expected version to 1
module coap_message_parser
    import coap_mp_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    coap_mp_in_if.sink     i_in,
    coap_mp_out_if.source  o_out,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_wdata
);

    logic [1:0] r_exp_ver;

    logic       s1_valid;
    logic [7:0] s1_data_byte;
    logic       s1_last_byte;
    logic       out_free;
    logic       take;
    logic       has_result;
    t_result    result;

    logic       r_out_valid;
    t_result    r_out;

    // configuration register; write it only while idle, the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_ver <= 2'd1;
        end else if (i_cfg_we) begin
            r_exp_ver <= i_cfg_wdata;
        end
    end

    // result register is free when empty or drained this cycle
    assign out_free = !r_out_valid || o_out.ready;
    // quiet bytes also wait for a free slot, which keeps ordering simple
    assign take     = s1_valid && out_free;

    coap_mp_in_stage u_in_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_take      (take),
        .o_valid     (s1_valid),
        .o_data_byte (s1_data_byte),
        .o_last_byte (s1_last_byte)
    );

    coap_mp_decode u_decode (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_step             (take),
        .i_data_byte        (s1_data_byte),
        .i_last_byte        (s1_last_byte),
        .i_expected_version (r_exp_ver),
        .o_has_result       (has_result),
        .o_result           (result)
    );

    // output register: loaded by a byte that makes an event or ends the datagram
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= has_result;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && has_result) begin
            r_out <= result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.kind          = r_out.kind;
    assign o_out.msg_type      = r_out.msg_type;
    assign o_out.token_len     = r_out.token_len;
    assign o_out.code          = r_out.code;
    assign o_out.msg_id        = r_out.msg_id;
    assign o_out.option_number = r_out.option_number;
    assign o_out.option_length = r_out.option_length;
    assign o_out.byte_out      = r_out.byte_out;
    assign o_out.message_end   = r_out.message_end;
    assign o_out.status        = r_out.status;

endmodule

// ===== sim/coap_message_parser_test.sv =====
module coap_message_parser_test;
    import coap_mp_pkg::*;

    // delta or length nibble that decodes as zero unless the byte is the marker
    localparam logic [3:0] NIB_RESERVED = 4'd15;
    // random datagram bytes owed to each setting of the version register
    localparam int unsigned ITEMS_PER_SETTING = 230;
    localparam int unsigned NUM_SETTINGS = 5;

    // parse position, kept in step with the block
    typedef enum logic [3:0] {
        P_HEADER, P_TOKEN, P_OPT, P_DEXT1, P_DEXT2,
        P_LEXT1, P_LEXT2, P_VALUE, P_PAYLOAD, P_DISCARD
    } t_parse_phase;

    // one datagram byte to send; pinned rows carry a kind and status typed in by hand
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       pinned;
        logic [2:0] kind;
        logic [2:0] status;
    } t_stim;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_wdata;

    coap_mp_in_if  in_ch ();
    coap_mp_out_if out_ch ();

    coap_message_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // bytes waiting to go out, and events the parser still owes us
    t_stim       byte_q[$];
    t_result     event_q[$];
    int unsigned fail_count = 0;
    int unsigned parsed_bytes = 0;

    // parser mirror: header fields, option walk and the sticky datagram status
    logic [1:0]   exp_version;
    t_parse_phase ph;
    logic [1:0]   hdr_idx;
    logic [1:0]   h_type;
    logic [3:0]   h_tkl;
    logic [7:0]   h_code;
    logic [15:0]  h_mid;
    logic [3:0]   tok_left;
    logic [3:0]   dnib;
    logic [3:0]   lnib;
    logic [7:0]   ext_hi;
    logic [15:0]  pend_delta;
    logic [15:0]  cur_num;
    logic [15:0]  val_left;
    int unsigned  opt_cnt;
    logic [2:0]   sticky_err;

    // directed datagrams, each ends on its last byte
    t_stim directed_rows [27] = '{
        // last byte inside the header
        '{8'h40, 1'b1, 1'b1, KIND_NONE,    ST_TOO_SHORT},
        // version 2 with a 9-byte token: the version wins
        '{8'h89, 1'b0, 1'b0, KIND_NONE,    ST_OK},
        '{8'h01, 1'b0, 1'b0, KIND_NONE,    ST_OK},
        '{8'h12, 1'b0, 1'b0, KIND_NONE,    ST_OK},
        '{8'h34, 1'b1, 1'b1, KIND_NONE,    ST_BAD_VERSION},
        // header with all-ones code and message id, one token byte, delta 14 wrapping to 268,
        // a one-byte value, a nibble-15 option, then payload
        '{8'h71, 1'b0, 1'b0, KIND_NONE,    ST_OK},
        '{8'hFF, 1'b0, 1'b0, KIND_NONE,    ST_OK},
        '{8'hFF, 1'b0, 1'b0, KIND_NONE,    ST_OK},
        '{8'hFF, 1'b0, 1'b1, KIND_HEADER,  ST_OK},
        '{8'h00, 1'b0, 1'b0, KIND_NONE,    ST_OK},
        '{8'hE1, 1'b0, 1'b0, KIND_NONE,    ST_OK},
        '{8'hFF, 1'b0, 1'b0, KIND_NONE,    ST_OK},
        '{8'hFF, 1'b0, 1'b0, KIND_NONE,    ST_OK},
        '{8'hAB, 1'b0, 1'b0, KIND_NONE,    ST_OK},
        '{8'hF0, 1'b0, 1'b0, KIND_NONE,    ST_OK},
        '{8'hFF, 1'b0, 1'b0, KIND_NONE,    ST_OK},
        '{8'h5A, 1'b1, 1'b1, KIND_PAYLOAD, ST_OK},
        // payload marker as the last byte: quiet end
        '{8'h40, 1'b0, 1'b0, KIND_NONE,    ST_OK},
        '{8'h00, 1'b0, 1'b0, KIND_NONE,    ST_OK},
        '{8'h00, 1'b0, 1'b0, KIND_NONE,    ST_OK},
        '{8'h00, 1'b0, 1'b1, KIND_HEADER,  ST_OK},
        '{8'hFF, 1'b1, 1'b1, KIND_NONE,    ST_OK},
        // option owes a value byte when the datagram ends
        '{8'h40, 1'b0, 1'b0, KIND_NONE,    ST_OK},
        '{8'h00, 1'b0, 1'b0, KIND_NONE,    ST_OK},
        '{8'h00, 1'b0, 1'b0, KIND_NONE,    ST_OK},
        '{8'h00, 1'b0, 1'b0, KIND_NONE,    ST_OK},
        '{8'h01, 1'b1, 1'b1, KIND_NONE,    ST_OVERRUN}
    };

    function automatic void clear_parse();
        ph = P_HEADER;
        hdr_idx = '0;
        h_type = '0;
        h_tkl = '0;
        h_code = '0;
        h_mid = '0;
        tok_left = '0;
        dnib = '0;
        lnib = '0;
        ext_hi = '0;
        pend_delta = '0;
        cur_num = '0;
        val_left = '0;
        opt_cnt = 0;
        sticky_err = ST_OK;
    endfunction

    // nibbles 13..15 carry no length of their own
    function automatic logic [15:0] nib_value(logic [3:0] n);
        return (n < NIB_EXT1) ? {12'd0, n} : 16'd0;
    endfunction

    // option header complete: bump the number and announce it
    function automatic void close_option(input logic last, inout logic [2:0] kind,
                                         inout logic [15:0] olen, inout logic [2:0] err);
        cur_num = cur_num + pend_delta;
        if (val_left != 16'd0 && last) begin
            err = ST_OVERRUN;
        end else begin
            opt_cnt++;
            kind = KIND_OPTION;
            olen = val_left;
            if (val_left != 16'd0) ph = P_VALUE;
            else ph = P_OPT;
        end
    endfunction

    // delta known: either fetch length extension bytes or finish the option now
    function automatic void resolve_length(input logic last, inout logic [2:0] kind,
                                           inout logic [15:0] olen, inout logic [2:0] err);
        if (lnib == NIB_EXT1 || lnib == NIB_EXT2) begin
            if (last) err = ST_OVERRUN;
            else ph = P_LEXT1;
        end else begin
            val_left = nib_value(lnib);
            close_option(last, kind, olen, err);
        end
    endfunction

    // advance the mirror by one byte; returns 1 when the parser owes an event
    function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                      output t_result ev);
        logic [2:0]  kind;
        logic [2:0]  err;
        logic [7:0]  bout;
        logic [15:0] olen;
        kind = KIND_NONE;
        err = ST_OK;
        bout = '0;
        olen = '0;
        ev = '0;
        case (ph)
            P_HEADER: begin
                case (hdr_idx)
                    2'd0: begin
                        h_type = b[5:4];
                        h_tkl = b[3:0];
                        if (b[7:6] != exp_version) sticky_err = ST_BAD_VERSION;
                    end
                    2'd1: h_code = b;
                    2'd2: h_mid = {b, 8'h00};
                    default: h_mid[7:0] = b;
                endcase
                if (hdr_idx != 2'd3) begin
                    hdr_idx = hdr_idx + 2'd1;
                    if (last) err = ST_TOO_SHORT;
                end else begin
                    hdr_idx = '0;
                    // version first, then token length, then a token cut short
                    if (sticky_err == ST_BAD_VERSION) err = ST_BAD_VERSION;
                    else if (32'(h_tkl) > MAX_TOKEN) err = ST_BAD_TOKEN;
                    else if (h_tkl != 4'd0 && last) err = ST_BAD_TOKEN;
                    else begin
                        if (h_tkl != 4'd0) begin
                            tok_left = h_tkl;
                            ph = P_TOKEN;
                        end else begin
                            ph = P_OPT;
                        end
                        kind = KIND_HEADER;
                    end
                end
            end
            P_TOKEN: begin
                tok_left = tok_left - 4'd1;
                if (tok_left == 4'd0) ph = P_OPT;
                else if (last) err = ST_BAD_TOKEN;
                if (err == ST_OK) begin
                    kind = KIND_TOKEN;
                    bout = b;
                end
            end
            P_OPT: begin
                if (b == PAYLOAD_MARKER) begin
                    ph = P_PAYLOAD;
                end else if (opt_cnt >= MAX_OPTIONS) begin
                    err = ST_TOO_MANY;
                end else begin
                    dnib = b[7:4];
                    lnib = b[3:0];
                    if (dnib == NIB_EXT1 || dnib == NIB_EXT2) begin
                        if (last) err = ST_OVERRUN;
                        else ph = P_DEXT1;
                    end else begin
                        pend_delta = nib_value(dnib);
                        resolve_length(last, kind, olen, err);
                    end
                end
            end
            P_DEXT1: begin
                if (dnib == NIB_EXT1) begin
                    pend_delta = {8'd0, b} + EXT1_BIAS;
                    resolve_length(last, kind, olen, err);
                end else begin
                    ext_hi = b;
                    if (last) err = ST_OVERRUN;
                    else ph = P_DEXT2;
                end
            end
            P_DEXT2: begin
                pend_delta = {ext_hi, b} + EXT2_BIAS;
                resolve_length(last, kind, olen, err);
            end
            P_LEXT1: begin
                if (lnib == NIB_EXT1) begin
                    val_left = {8'd0, b} + EXT1_BIAS;
                    close_option(last, kind, olen, err);
                end else begin
                    ext_hi = b;
                    if (last) err = ST_OVERRUN;
                    else ph = P_LEXT2;
                end
            end
            P_LEXT2: begin
                val_left = {ext_hi, b} + EXT2_BIAS;
                close_option(last, kind, olen, err);
            end
            P_VALUE: begin
                val_left = val_left - 16'd1;
                if (val_left == 16'd0) ph = P_OPT;
                else if (last) err = ST_OVERRUN;
                if (err == ST_OK) begin
                    kind = KIND_VALUE;
                    bout = b;
                end
            end
            P_PAYLOAD: begin
                kind = KIND_PAYLOAD;
                bout = b;
            end
            default: begin
                // dropping bytes; the last one reports what went wrong
                if (last) err = sticky_err;
            end
        endcase

        // the byte that finds an error gives no event of its own, only the end report if it is last
        if (err != ST_OK) begin
            kind = KIND_NONE;
            bout = '0;
            olen = '0;
            sticky_err = err;
            ph = P_DISCARD;
        end
        if (kind == KIND_NONE && !last) return 1'b0;

        ev.kind = kind;
        if (kind != KIND_NONE) begin
            ev.msg_type = h_type;
            ev.token_len = h_tkl;
            ev.code = h_code;
            ev.msg_id = h_mid;
        end
        if (kind == KIND_OPTION || kind == KIND_VALUE) ev.option_number = cur_num;
        if (kind == KIND_OPTION) ev.option_length = olen;
        ev.byte_out = bout;
        ev.message_end = last;
        ev.status = last ? sticky_err : ST_OK;
        // every datagram end puts the parser back at the header
        if (last) clear_parse();
        return 1'b1;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // nothing queued, nothing in flight, then a pause for quiet bytes
    task automatic wait_drained();
        do @(negedge i_clk);
        while (byte_q.size() != 0 || in_ch.valid || event_q.size() != 0);
        repeat (6) @(negedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // byte sender: bursts of random length with random gaps in between
    initial begin
        t_stim       cur_row;
        t_result     ev;
        int unsigned burst_left;
        int unsigned gap_left;
        cur_row = '0;
        burst_left = 1;
        gap_left = 0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.last_byte = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                in_ch.valid <= 1'b0;
            end else begin
                // transfer on this edge: run the mirror and queue its event
                if (in_ch.valid && in_ch.ready) begin
                    if (ph != P_DISCARD) parsed_bytes++;
                    if (parse_byte(in_ch.data_byte, in_ch.last_byte, ev)) begin
                        if (cur_row.pinned) begin
                            ev.kind = cur_row.kind;
                            ev.status = cur_row.status;
                        end
                        event_q.push_back(ev);
                    end
                end
                if (!in_ch.valid || in_ch.ready) begin
                    if (gap_left != 0 || byte_q.size() == 0) begin
                        in_ch.valid <= 1'b0;
                        if (gap_left != 0) gap_left--;
                    end else begin
                        cur_row = byte_q.pop_front();
                        in_ch.valid <= 1'b1;
                        in_ch.data_byte <= cur_row.data;
                        in_ch.last_byte <= cur_row.last;
                        if (burst_left <= 1) begin
                            burst_left = $urandom_range(1, 24);
                            // a quarter of the bursts run straight on
                            gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
                        end else begin
                            burst_left--;
                        end
                    end
                end
            end
        end
    end

    // event receiver: checks each transfer, stalls in changing modes
    initial begin
        t_result     want;
        int unsigned stall_mode;
        int unsigned mode_left;
        int unsigned cyc;
        stall_mode = 0;
        mode_left = 0;
        cyc = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
            end else begin
                if (out_ch.valid && out_ch.ready) begin
                    if (event_q.size() == 0) begin
                        $error("event with none expected: kind %0d status %0d",
                               out_ch.kind, out_ch.status);
                        fail_count++;
                    end else begin
                        want = event_q.pop_front();
                        check_field("kind", 16'(want.kind), 16'(out_ch.kind));
                        check_field("msg_type", 16'(want.msg_type), 16'(out_ch.msg_type));
                        check_field("token_len", 16'(want.token_len),
                                    16'(out_ch.token_len));
                        check_field("code", 16'(want.code), 16'(out_ch.code));
                        check_field("msg_id", want.msg_id, out_ch.msg_id);
                        check_field("option_number", want.option_number,
                                    out_ch.option_number);
                        check_field("option_length", want.option_length,
                                    out_ch.option_length);
                        check_field("byte_out", 16'(want.byte_out), 16'(out_ch.byte_out));
                        check_field("message_end", 16'(want.message_end),
                                    16'(out_ch.message_end));
                        check_field("status", 16'(want.status), 16'(out_ch.status));
                    end
                end
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(3);
                    mode_left = $urandom_range(20, 200);
                end else begin
                    mode_left--;
                end
                cyc++;
                case (stall_mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= 1'($urandom_range(1));
                    2: out_ch.ready <= (cyc % 3) != 0;
                    // heavy backpressure
                    default: out_ch.ready <= ($urandom_range(7) == 0);
                endcase
            end
        end
    end

    // reset, directed datagrams, then random datagrams under each version setting
    initial begin
        logic [7:0]  msg[$];
        t_stim       row;
        logic [1:0]  ver;
        logic [1:0]  new_ver;
        logic [3:0]  tkl;
        logic [3:0]  d_n;
        logic [3:0]  l_n;
        logic [7:0]  ext;
        int unsigned n_opts;
        int unsigned n_value;
        int unsigned pick;
        int unsigned keep;
        int unsigned setting;
        int unsigned byte_target;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        exp_version = 2'd1;
        clear_parse();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        foreach (directed_rows[i]) byte_q.push_back(directed_rows[i]);

        byte_target = 0;
        for (setting = 0; setting < NUM_SETTINGS; setting++) begin
            // version register: reset value first, then both extremes and the rest
            if (setting != 0) begin
                wait_drained();
                case (setting)
                    1: new_ver = 2'd0;
                    2: new_ver = 2'd3;
                    3: new_ver = 2'd2;
                    default: new_ver = 2'($urandom_range(3));
                endcase
                @(posedge i_clk);
                i_cfg_we <= 1'b1;
                i_cfg_wdata <= new_ver;
                @(posedge i_clk);
                i_cfg_we <= 1'b0;
                exp_version = new_ver;
                @(negedge i_clk);
            end

            byte_target += ITEMS_PER_SETTING;
            while (parsed_bytes < byte_target) begin
                msg.delete();
                if ($urandom_range(99) < 8) begin
                    // raw noise
                    repeat ($urandom_range(1, 24)) msg.push_back(8'($urandom_range(255)));
                end else begin
                    ver = ($urandom_range(19) == 0) ? 2'($urandom_range(3)) : exp_version;
                    tkl = ($urandom_range(15) == 0) ? 4'($urandom_range(15))
                                                    : 4'($urandom_range(MAX_TOKEN));
                    msg.push_back({ver, 2'($urandom_range(3)), tkl});
                    // code, message id and token
                    repeat (3 + int'(tkl)) msg.push_back(8'($urandom_range(255)));
                    // now and then more options than the parser takes
                    n_opts = ($urandom_range(19) == 0)
                           ? $urandom_range(MAX_OPTIONS + 1, MAX_OPTIONS + 3)
                           : $urandom_range(5);
                    repeat (n_opts) begin
                        pick = $urandom_range(9);
                        if (pick < 7) d_n = 4'($urandom_range(12));
                        else if (pick == 7) d_n = NIB_EXT1;
                        else if (pick == 8) d_n = NIB_EXT2;
                        else d_n = NIB_RESERVED;
                        // short values mostly, two-byte lengths rarely
                        pick = $urandom_range(29);
                        if (pick < 16) l_n = 4'($urandom_range(3));
                        else if (pick < 24) l_n = 4'($urandom_range(12));
                        else if (pick < 27) l_n = NIB_EXT1;
                        else if (pick < 29) l_n = NIB_RESERVED;
                        else l_n = NIB_EXT2;
                        if ({d_n, l_n} == PAYLOAD_MARKER) l_n = 4'd0;
                        msg.push_back({d_n, l_n});
                        if (d_n == NIB_EXT1) begin
                            msg.push_back(8'($urandom_range(255)));
                        end else if (d_n == NIB_EXT2) begin
                            msg.push_back(8'($urandom_range(255)));
                            msg.push_back(8'($urandom_range(255)));
                        end
                        if (l_n == NIB_EXT1) begin
                            ext = ($urandom_range(19) == 0) ? 8'($urandom_range(255))
                                                            : 8'($urandom_range(8));
                            msg.push_back(ext);
                            n_value = int'(ext) + 13;
                        end else if (l_n == NIB_EXT2) begin
                            ext = 8'($urandom_range(20));
                            msg.push_back(8'h00);
                            msg.push_back(ext);
                            n_value = int'(ext) + 269;
                        end else begin
                            n_value = int'(nib_value(l_n));
                        end
                        repeat (n_value) msg.push_back(8'($urandom_range(255)));
                    end
                    if ($urandom_range(2) != 0) begin
                        msg.push_back(PAYLOAD_MARKER);
                        repeat ($urandom_range(6)) msg.push_back(8'($urandom_range(255)));
                    end
                    // cut some datagrams short anywhere
                    if ($urandom_range(9) == 0) begin
                        keep = $urandom_range(1, msg.size());
                        while (msg.size() > keep) void'(msg.pop_back());
                    end
                end
                foreach (msg[i]) begin
                    row = '0;
                    row.data = msg[i];
                    row.last = (i == msg.size() - 1);
                    byte_q.push_back(row);
                end
                // keep the sender fed without running far ahead
                while (byte_q.size() > 8) @(negedge i_clk);
            end
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #4000000;
        $display("FAIL");
        $finish;
    end

endmodule
